// File: rtl/kmer_heaviest_bucket_assign_macros.svh
// Assertion macros for the heaviest-bucket assignment block.
// Included by the RTL files that check their own logic; depends on nothing.
`ifndef KMER_HEAVIEST_BUCKET_ASSIGN_MACROS_SVH
`define KMER_HEAVIEST_BUCKET_ASSIGN_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on aclk, ignored while aresetn is low.
`define KHB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on aclk, also during reset.
`define KHB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define KHB_ASSERT(lbl, prop, msg)
`define KHB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/kmhb_pkg.sv
// Shared constants, types and the base decoder of the heaviest-bucket block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package kmhb_pkg;

    // Built defaults of the top-level parameters.
    localparam int DEF_MAX_K        = 10;
    localparam int DEF_MAX_READ_LEN = 256;
    localparam int DEF_COUNT_BITS   = 32;

    // Fixed field widths.
    localparam int OFFSET_BITS   = 8;
    localparam int CHAR_BITS     = 8;
    localparam int KLEN_BITS     = 4;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_KMER_LENGTH = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NO_RC       = 1'd1;

    // Configuration reset values.
    localparam logic [KLEN_BITS-1:0] KLEN_RESET = 4'd10;

    // ASCII codes of the four bases in both cases.
    localparam logic [CHAR_BITS-1:0] CHAR_UA = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_UC = 8'h43;
    localparam logic [CHAR_BITS-1:0] CHAR_UG = 8'h47;
    localparam logic [CHAR_BITS-1:0] CHAR_UT = 8'h54;
    localparam logic [CHAR_BITS-1:0] CHAR_LA = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_LC = 8'h63;
    localparam logic [CHAR_BITS-1:0] CHAR_LG = 8'h67;
    localparam logic [CHAR_BITS-1:0] CHAR_LT = 8'h74;

    // 2-bit base codes.
    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    // Control flags of one candidate beat between the roller and the selector.
    typedef struct packed {
        logic f_ok;   // forward k-mer is complete
        logic r_ok;   // reverse-complement k-mer is a candidate
        logic last;   // beat ends the read
    } cand_ctl_t;

    // Decoded base: a byte that is not a base reads as A on both strands.
    typedef struct packed {
        logic [1:0] fwd;
        logic [1:0] rev;
    } base_code_t;

    function automatic base_code_t decode_base(input logic [CHAR_BITS-1:0] ch);
        base_code_t res;
        case (ch)
            CHAR_UA, CHAR_LA: res = '{fwd: CODE_A, rev: CODE_T};
            CHAR_UC, CHAR_LC: res = '{fwd: CODE_C, rev: CODE_G};
            CHAR_UG, CHAR_LG: res = '{fwd: CODE_G, rev: CODE_C};
            CHAR_UT, CHAR_LT: res = '{fwd: CODE_T, rev: CODE_A};
            default:          res = '{fwd: CODE_A, rev: CODE_A};
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/kmhb_roller.sv
// Rolling forward and reverse-complement k-mers, window fill and read position.
// Produces the lookup keys of each accepted base; uses kmhb_pkg.
`default_nettype none

module kmhb_roller #(
    parameter int MAX_K        = kmhb_pkg::DEF_MAX_K,
    parameter int MAX_READ_LEN = kmhb_pkg::DEF_MAX_READ_LEN
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              accept,
    input  wire logic [kmhb_pkg::CHAR_BITS-1:0]    base_char,
    input  wire logic                              last_base,
    input  wire logic [kmhb_pkg::KLEN_BITS-1:0]    kmer_length,
    input  wire logic                              no_rc,
    output kmhb_pkg::cand_ctl_t                    cand_ctl,
    output logic [2*MAX_K-1:0]                     fwd_key,
    output logic [2*MAX_K-1:0]                     rev_key,
    output logic [$clog2(MAX_READ_LEN)-1:0]        fwd_pos,
    output logic [$clog2(MAX_READ_LEN)-1:0]        rev_pos,
    output logic [$clog2(MAX_READ_LEN)-1:0]        end_pos
);

    localparam int KEY_BITS = 2 * MAX_K;
    localparam int KL_BITS  = $clog2(MAX_K + 1);
    localparam int POS_BITS = $clog2(MAX_READ_LEN);
    localparam int RP_BITS  = POS_BITS + 1;

    logic [KEY_BITS-1:0] fwd_kmer_reg, fwd_kmer_next;
    logic [KEY_BITS-1:0] rev_kmer_reg, rev_kmer_next;
    logic [KL_BITS-1:0]  win_reg, win_next;
    logic [RP_BITS-1:0]  rpos_reg, rpos_next;

    logic [KL_BITS-1:0]  k_eff;
    logic [KL_BITS-1:0]  rev_shift;
    logic                active;
    logic [KEY_BITS-1:0] fwd_roll;
    logic [KEY_BITS-1:0] rev_roll;
    logic [KEY_BITS-1:0] fwd_mask;
    kmhb_pkg::base_code_t code;

    // Effective k-mer length: zero acts as one, anything above the build limit
    // acts as the limit.
    always_comb begin
        if (kmer_length == '0) begin
            k_eff = KL_BITS'(1);
        end else if (kmer_length > MAX_K) begin
            k_eff = KL_BITS'(MAX_K);
        end else begin
            k_eff = KL_BITS'(kmer_length);
        end
    end

    // Shift the new base into both strands; bases past the read limit are dropped.
    assign code     = kmhb_pkg::decode_base(base_char);
    assign active   = (rpos_reg < RP_BITS'(MAX_READ_LEN));
    assign fwd_roll = {fwd_kmer_reg[KEY_BITS-3:0], code.fwd};
    assign rev_roll = {code.rev, rev_kmer_reg[KEY_BITS-1:2]};

    always_comb begin
        fwd_kmer_next = fwd_kmer_reg;
        rev_kmer_next = rev_kmer_reg;
        win_next      = win_reg;
        rpos_next     = rpos_reg;
        if (active) begin
            fwd_kmer_next = fwd_roll;
            rev_kmer_next = rev_roll;
            rpos_next     = rpos_reg + RP_BITS'(1);
            if (win_reg < KL_BITS'(MAX_K)) begin
                win_next = win_reg + KL_BITS'(1);
            end
        end
    end

    // Keys: the forward key keeps the low k bases, the reverse key drops the
    // oldest MAX_K-k bases from the low end.
    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            fwd_mask[2*i +: 2] = (i < k_eff) ? 2'b11 : 2'b00;
        end
    end

    assign rev_shift = KL_BITS'(MAX_K) - k_eff;
    assign fwd_key   = fwd_roll & fwd_mask;
    assign rev_key   = rev_roll >> {rev_shift, 1'b0};

    assign cand_ctl.f_ok = active && (win_next >= k_eff);
    assign cand_ctl.r_ok = active && (win_next >= k_eff) && !no_rc;
    assign cand_ctl.last = last_base;

    assign fwd_pos = POS_BITS'(rpos_reg + RP_BITS'(1) - RP_BITS'(k_eff));
    assign rev_pos = POS_BITS'(rpos_reg);
    assign end_pos = POS_BITS'(rpos_next - RP_BITS'(1));

    // Window state; everything returns to its reset value after the last base.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_kmer_reg <= '1;
            rev_kmer_reg <= '1;
            win_reg      <= '0;
            rpos_reg     <= '0;
        end else if (accept) begin
            if (last_base) begin
                fwd_kmer_reg <= '1;
                rev_kmer_reg <= '1;
                win_reg      <= '0;
                rpos_reg     <= '0;
            end else begin
                fwd_kmer_reg <= fwd_kmer_next;
                rev_kmer_reg <= rev_kmer_next;
                win_reg      <= win_next;
                rpos_reg     <= rpos_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/kmhb_count_mem.sv
// Bucket count memory: two registered read ports, one write port, a clearing
// pass after reset and forwarding of a write that meets a read. Uses kmhb_pkg.
`default_nettype none
`include "kmer_heaviest_bucket_assign_macros.svh"

module kmhb_count_mem #(
    parameter int MAX_K      = kmhb_pkg::DEF_MAX_K,
    parameter int COUNT_BITS = kmhb_pkg::DEF_COUNT_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  rd_en,
    input  wire logic [2*MAX_K-1:0]    rd_addr0,
    input  wire logic [2*MAX_K-1:0]    rd_addr1,
    output logic [COUNT_BITS-1:0]      rd_data0,
    output logic [COUNT_BITS-1:0]      rd_data1,
    input  wire logic                  inc_we,
    input  wire logic [2*MAX_K-1:0]    inc_addr,
    input  wire logic [COUNT_BITS-1:0] inc_data,
    output logic                       clr_busy
);

    localparam int KEY_BITS = 2 * MAX_K;
    localparam int DEPTH    = 1 << KEY_BITS;

    logic [COUNT_BITS-1:0] mem [DEPTH];

    logic                  clr_busy_reg;
    logic [KEY_BITS-1:0]   clr_addr_reg;

    logic                  wr_en;
    logic [KEY_BITS-1:0]   wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    logic [COUNT_BITS-1:0] q0_reg, q1_reg;
    logic                  hit0_reg, hit1_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    // Clearing pass: one entry a cycle from address zero up after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + KEY_BITS'(1);
            if (clr_addr_reg == '1) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign clr_busy = clr_busy_reg;
    assign wr_en    = clr_busy_reg || inc_we;
    assign wr_addr  = clr_busy_reg ? clr_addr_reg : inc_addr;
    assign wr_data  = clr_busy_reg ? '0 : inc_data;

    // Array access: reads return the contents before a write at the same edge.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q0_reg <= mem[rd_addr0];
            q1_reg <= mem[rd_addr1];
        end
    end

    // Note a write that lands at the same edge as a read of the same entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit0_reg <= 1'b0;
            hit1_reg <= 1'b0;
        end else if (rd_en) begin
            hit0_reg <= wr_en && (wr_addr == rd_addr0);
            hit1_reg <= wr_en && (wr_addr == rd_addr1);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data0 = hit0_reg ? fwd_data_reg : q0_reg;
    assign rd_data1 = hit1_reg ? fwd_data_reg : q1_reg;

    `KHB_ASSERT(a_no_read_in_clear, clr_busy_reg |-> !rd_en, "count read during clearing pass")
    `KHB_ASSERT(a_clear_full_sweep, $fell(clr_busy_reg) |-> ($past(clr_addr_reg) == '1), "clearing pass ended early")

endmodule

`default_nettype wire

// File: rtl/kmhb_select.sv
// Candidate stage: compares the looked-up counts with the best so far, holds
// the result beat and issues the saturating count increment. Uses kmhb_pkg.
`default_nettype none
`include "kmer_heaviest_bucket_assign_macros.svh"

module kmhb_select #(
    parameter int MAX_K        = kmhb_pkg::DEF_MAX_K,
    parameter int MAX_READ_LEN = kmhb_pkg::DEF_MAX_READ_LEN,
    parameter int COUNT_BITS   = kmhb_pkg::DEF_COUNT_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                accept,
    input  wire kmhb_pkg::cand_ctl_t                 cand_ctl,
    input  wire logic [2*MAX_K-1:0]                  fwd_key,
    input  wire logic [2*MAX_K-1:0]                  rev_key,
    input  wire logic [$clog2(MAX_READ_LEN)-1:0]     fwd_pos,
    input  wire logic [$clog2(MAX_READ_LEN)-1:0]     rev_pos,
    input  wire logic [$clog2(MAX_READ_LEN)-1:0]     end_pos,
    input  wire logic [COUNT_BITS-1:0]               fwd_weight,
    input  wire logic [COUNT_BITS-1:0]               rev_weight,
    output logic                                     stage_free,
    output logic                                     inc_we,
    output logic [2*MAX_K-1:0]                       inc_addr,
    output logic [COUNT_BITS-1:0]                    inc_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_found,
    output logic [2*MAX_K-1:0]                       m_bucket_key,
    output logic [kmhb_pkg::OFFSET_BITS-1:0]         m_first_offset,
    output logic                                     m_reversed,
    output logic [COUNT_BITS-1:0]                    m_bucket_weight
);

    localparam int KEY_BITS = 2 * MAX_K;
    localparam int POS_BITS = $clog2(MAX_READ_LEN);

    // Beat waiting for its count data.
    logic                 s1_valid_reg;
    kmhb_pkg::cand_ctl_t  s1_ctl_reg;
    logic [KEY_BITS-1:0]  s1_fkey_reg, s1_rkey_reg;
    logic [POS_BITS-1:0]  s1_fpos_reg, s1_rpos_reg, s1_end_reg;

    // Best candidate of the current read.
    logic                  have_best_reg;
    logic [KEY_BITS-1:0]   best_key_reg;
    logic [COUNT_BITS-1:0] best_weight_reg;
    logic [POS_BITS-1:0]   best_pos_reg;
    logic                  best_rev_reg;

    logic                  m_valid_reg;

    logic                  s1_adv;
    logic                  emit;
    logic                  take_f, take_r;
    logic                  t_have;
    logic [KEY_BITS-1:0]   t_key, b_key;
    logic [COUNT_BITS-1:0] t_weight, b_weight;
    logic [POS_BITS-1:0]   t_pos, b_pos, b_off;
    logic                  t_rev, b_rev, b_have;

    // The beat moves on unless it carries a result and the output is still full.
    assign s1_adv     = s1_valid_reg && !(s1_ctl_reg.last && m_valid_reg && !m_ready);
    assign stage_free = !s1_valid_reg || s1_adv;
    assign emit       = s1_adv && s1_ctl_reg.last;

    // Forward candidate first: higher count wins, smaller key breaks a tie.
    always_comb begin
        take_f = s1_ctl_reg.f_ok && (!have_best_reg || (fwd_weight > best_weight_reg) ||
                 ((fwd_weight == best_weight_reg) && (s1_fkey_reg < best_key_reg)));
        t_have   = have_best_reg || take_f;
        t_key    = take_f ? s1_fkey_reg : best_key_reg;
        t_weight = take_f ? fwd_weight  : best_weight_reg;
        t_pos    = take_f ? s1_fpos_reg : best_pos_reg;
        t_rev    = take_f ? 1'b0        : best_rev_reg;
    end

    // Then the reverse-complement candidate of the same base.
    always_comb begin
        take_r = s1_ctl_reg.r_ok && (!t_have || (rev_weight > t_weight) ||
                 ((rev_weight == t_weight) && (s1_rkey_reg < t_key)));
        b_have   = t_have || take_r;
        b_key    = take_r ? s1_rkey_reg : t_key;
        b_weight = take_r ? rev_weight  : t_weight;
        b_pos    = take_r ? s1_rpos_reg : t_pos;
        b_rev    = take_r ? 1'b1        : t_rev;
        b_off    = b_rev ? (s1_end_reg - b_pos) : b_pos;
    end

    // Count increment of the chosen bucket, held at the top value.
    assign inc_we   = emit && b_have && (b_weight != '1);
    assign inc_addr = b_key;
    assign inc_data = b_weight + COUNT_BITS'(1);

    // Stage valid, best-candidate state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            have_best_reg   <= 1'b0;
            best_key_reg    <= '0;
            best_weight_reg <= '0;
            best_pos_reg    <= '0;
            best_rev_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (emit) begin
                have_best_reg   <= 1'b0;
                best_key_reg    <= '0;
                best_weight_reg <= '0;
                best_pos_reg    <= '0;
                best_rev_reg    <= 1'b0;
            end else if (s1_adv) begin
                have_best_reg   <= b_have;
                best_key_reg    <= b_key;
                best_weight_reg <= b_weight;
                best_pos_reg    <= b_pos;
                best_rev_reg    <= b_rev;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Beat payload captured at acceptance.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctl_reg  <= cand_ctl;
            s1_fkey_reg <= fwd_key;
            s1_rkey_reg <= rev_key;
            s1_fpos_reg <= fwd_pos;
            s1_rpos_reg <= rev_pos;
            s1_end_reg  <= end_pos;
        end
    end

    // Result payload; a read without a full k-mer reports zeros.
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_found         <= b_have;
            m_bucket_key    <= b_have ? b_key : '0;
            m_first_offset  <= b_have ? kmhb_pkg::OFFSET_BITS'(b_off) : '0;
            m_reversed      <= b_have && b_rev;
            m_bucket_weight <= b_have ? b_weight : '0;
        end
    end

    assign m_valid = m_valid_reg;

    `KHB_ASSERT(a_hold_stalled_beat, (s1_valid_reg && !s1_adv) |-> !accept, "beat overwritten while stalled")
    `KHB_ASSERT(a_best_cleared, emit |=> (!have_best_reg && m_valid_reg), "best not cleared after result")
    `KHB_ASSERT(a_not_found_zero, (m_valid_reg && !m_found) |-> ((m_bucket_weight == '0) && (m_bucket_key == '0)), "empty result carries data")

endmodule

`default_nettype wire

// File: rtl/kmer_heaviest_bucket_assign.sv
// Top level of the heaviest-bucket assignment block: configuration registers,
// input handshake and the roller, count memory and selector. Uses kmhb_pkg.
//
// Usage:
//   Bases of one read arrive on the s_ channel, one beat per base, with
//   s_last_base high on the final base. Each read produces exactly one beat on
//   the m_ channel: the heaviest bucket key of the read, its strand, its start
//   offset and its count before this read, or m_found low for a short read.
//   Throughput is one base per cycle while s_ready is high; the two read ports
//   of the count memory serve the forward and reverse lookups of a base together.
//   The edge that accepts the last base does the count lookup; the compare
//   follows and is registered as the result beat; a full, stalled output delays it.
//   The count increment is written back as the result is registered and is
//   forwarded to a lookup issued at that same edge.
//   After reset the count memory is cleared one entry a cycle, 4^MAX_K entries
//   (1048576 at the default size); s_ready stays low until it is done, while
//   configuration writes are taken throughout.
//   A stalled receiver holds the result beat; bases keep flowing until the
//   next read's last base reaches the compare stage, which then waits.
//   Write kmer_length and no_rc only while the block is idle.
`default_nettype none

module kmer_heaviest_bucket_assign #(
    parameter int MAX_K        = kmhb_pkg::DEF_MAX_K,
    parameter int MAX_READ_LEN = kmhb_pkg::DEF_MAX_READ_LEN,
    parameter int COUNT_BITS   = kmhb_pkg::DEF_COUNT_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [kmhb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [kmhb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [kmhb_pkg::CHAR_BITS-1:0]       s_base_char,
    input  wire logic                                 s_last_base,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_found,
    output logic [2*MAX_K-1:0]                        m_bucket_key,
    output logic [kmhb_pkg::OFFSET_BITS-1:0]          m_first_offset,
    output logic                                      m_reversed,
    output logic [COUNT_BITS-1:0]                     m_bucket_weight
);

    localparam int KEY_BITS = 2 * MAX_K;
    localparam int POS_BITS = $clog2(MAX_READ_LEN);

    logic [kmhb_pkg::KLEN_BITS-1:0] kmer_length_reg;
    logic                           no_rc_reg;

    logic                  accept;
    logic                  stage_free;
    logic                  clr_busy;
    kmhb_pkg::cand_ctl_t   cand_ctl;
    logic [KEY_BITS-1:0]   fwd_key, rev_key;
    logic [POS_BITS-1:0]   fwd_pos, rev_pos, end_pos;
    logic [COUNT_BITS-1:0] fwd_weight, rev_weight;
    logic                  inc_we;
    logic [KEY_BITS-1:0]   inc_addr;
    logic [COUNT_BITS-1:0] inc_data;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_length_reg <= kmhb_pkg::KLEN_RESET;
            no_rc_reg       <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                kmhb_pkg::CFG_KMER_LENGTH: kmer_length_reg <= cfg_data;
                kmhb_pkg::CFG_NO_RC:       no_rc_reg       <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // A base is taken when the clearing pass is over and the compare stage
    // can take a new beat.
    assign s_ready = !clr_busy && stage_free;
    assign accept  = s_valid && s_ready;

    kmhb_roller #(
        .MAX_K        (MAX_K),
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_roller (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .base_char   (s_base_char),
        .last_base   (s_last_base),
        .kmer_length (kmer_length_reg),
        .no_rc       (no_rc_reg),
        .cand_ctl    (cand_ctl),
        .fwd_key     (fwd_key),
        .rev_key     (rev_key),
        .fwd_pos     (fwd_pos),
        .rev_pos     (rev_pos),
        .end_pos     (end_pos)
    );

    kmhb_count_mem #(
        .MAX_K      (MAX_K),
        .COUNT_BITS (COUNT_BITS)
    ) u_count_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr0 (fwd_key),
        .rd_addr1 (rev_key),
        .rd_data0 (fwd_weight),
        .rd_data1 (rev_weight),
        .inc_we   (inc_we),
        .inc_addr (inc_addr),
        .inc_data (inc_data),
        .clr_busy (clr_busy)
    );

    kmhb_select #(
        .MAX_K        (MAX_K),
        .MAX_READ_LEN (MAX_READ_LEN),
        .COUNT_BITS   (COUNT_BITS)
    ) u_select (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .cand_ctl        (cand_ctl),
        .fwd_key         (fwd_key),
        .rev_key         (rev_key),
        .fwd_pos         (fwd_pos),
        .rev_pos         (rev_pos),
        .end_pos         (end_pos),
        .fwd_weight      (fwd_weight),
        .rev_weight      (rev_weight),
        .stage_free      (stage_free),
        .inc_we          (inc_we),
        .inc_addr        (inc_addr),
        .inc_data        (inc_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_found),
        .m_bucket_key    (m_bucket_key),
        .m_first_offset  (m_first_offset),
        .m_reversed      (m_reversed),
        .m_bucket_weight (m_bucket_weight)
    );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for kmer_heaviest_bucket_assign: random reads, a bucket-count predictor.
// Depends on kmhb_pkg for the field widths, the register indexes and the base character codes.
// The driver, the monitor and the receiver stalls are clocked blocks; an initial block runs the phases.
module tb_top;

    localparam int MAX_K         = kmhb_pkg::DEF_MAX_K;
    localparam int MAX_READ_LEN  = kmhb_pkg::DEF_MAX_READ_LEN;
    localparam int COUNT_BITS    = kmhb_pkg::DEF_COUNT_BITS;
    localparam int CHAR_BITS     = kmhb_pkg::CHAR_BITS;
    localparam int OFFSET_BITS   = kmhb_pkg::OFFSET_BITS;
    localparam int CFG_IDX_BITS  = kmhb_pkg::CFG_IDX_BITS;
    localparam int CFG_DATA_BITS = kmhb_pkg::CFG_DATA_BITS;
    localparam int KLEN_BITS     = kmhb_pkg::KLEN_BITS;
    localparam int KB            = 2 * MAX_K;
    // The first term covers the clearing pass after reset; the rest is margin for the reads.
    localparam int LIMIT        = (1 << KB) + 1_000_000;

    typedef struct {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } base_beat_t;

    typedef struct packed {
        logic                    found;
        logic [KB-1:0]           key;
        logic [OFFSET_BITS-1:0]  offset;
        logic                    rev;
        logic [COUNT_BITS-1:0]   weight;
    } bucket_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CHAR_BITS-1:0] s_base_char = '0;
    logic s_last_base = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_found;
    logic [KB-1:0] m_bucket_key;
    logic [OFFSET_BITS-1:0] m_first_offset;
    logic m_reversed;
    logic [COUNT_BITS-1:0] m_bucket_weight;

    kmer_heaviest_bucket_assign uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_base_char     (s_base_char),
        .s_last_base     (s_last_base),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_found),
        .m_bucket_key    (m_bucket_key),
        .m_first_offset  (m_first_offset),
        .m_reversed      (m_reversed),
        .m_bucket_weight (m_bucket_weight)
    );

    always #1 aclk = ~aclk;

    // Stimulus and expectation stores.
    base_beat_t     pending_bases[$];
    bucket_result_t expected_results[$];
    int queued_count = 0;
    int accepted_count = 0;
    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_gap = 0;
    int stall_left = 0;

    // Library of earlier reads, replayed so that bucket counts climb and ties appear.
    logic [CHAR_BITS-1:0] lib_chars[$];
    int lib_start[$];
    int lib_len[$];

    // Predictor state: register copies, the rolling window and the count table.
    logic [KLEN_BITS-1:0] cur_klen = kmhb_pkg::KLEN_RESET;
    logic cur_no_rc = 1'b0;
    logic [KB-1:0] fwd_kmer = '1;
    logic [KB-1:0] rev_kmer = '1;
    int win_fill = 0;
    int read_pos = 0;
    logic [KB-1:0] best_key = '0;
    logic [COUNT_BITS-1:0] best_weight = '0;
    int best_pos = 0;
    logic best_rev = 1'b0;
    logic have_best = 1'b0;
    bit [COUNT_BITS-1:0] bucket_count [0:(1<<KB)-1];

    // Gap length: mostly short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [CHAR_BITS-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: pick_char = (r < 85) ? kmhb_pkg::CHAR_UA : kmhb_pkg::CHAR_LA;
            1: pick_char = (r < 85) ? kmhb_pkg::CHAR_UC : kmhb_pkg::CHAR_LC;
            2: pick_char = (r < 85) ? kmhb_pkg::CHAR_UG : kmhb_pkg::CHAR_LG;
            default: pick_char = (r < 85) ? kmhb_pkg::CHAR_UT : kmhb_pkg::CHAR_LT;
        endcase
        if (r >= 92) pick_char = 8'($urandom_range(0, 255));
        else if (r >= 88) pick_char = "N";
    endfunction

    function automatic int char_code(input logic [CHAR_BITS-1:0] ch);
        case (ch)
            kmhb_pkg::CHAR_UA, kmhb_pkg::CHAR_LA: return int'(kmhb_pkg::CODE_A);
            kmhb_pkg::CHAR_UC, kmhb_pkg::CHAR_LC: return int'(kmhb_pkg::CODE_C);
            kmhb_pkg::CHAR_UG, kmhb_pkg::CHAR_LG: return int'(kmhb_pkg::CODE_G);
            kmhb_pkg::CHAR_UT, kmhb_pkg::CHAR_LT: return int'(kmhb_pkg::CODE_T);
            default:                              return 4;
        endcase
    endfunction

    // One candidate against the best so far: heavier wins, then the smaller key.
    task automatic weigh_candidate(input logic [KB-1:0] key, input int pos, input logic rev);
        logic [COUNT_BITS-1:0] w;
        w = bucket_count[key];
        if (!have_best || w > best_weight || (w == best_weight && key < best_key)) begin
            have_best = 1'b1;
            best_key = key;
            best_weight = w;
            best_pos = pos;
            best_rev = rev;
        end
    endtask

    // Predict the effect of one accepted base beat.
    task automatic take_base(input logic [CHAR_BITS-1:0] ch, input logic last);
        int k;
        int code;
        logic [1:0] fc;
        logic [1:0] rc;
        logic [KB-1:0] fkey;
        logic [KB-1:0] rkey;
        bucket_result_t res;
        k = int'(cur_klen);
        if (k < 1) k = 1;
        if (k > MAX_K) k = MAX_K;
        if (read_pos < MAX_READ_LEN) begin
            code = char_code(ch);
            if (code > 3) begin
                fc = kmhb_pkg::CODE_A;
                rc = kmhb_pkg::CODE_A;
            end else begin
                fc = 2'(code);
                rc = 2'(3 - code);
            end
            fwd_kmer = {fwd_kmer[KB-3:0], fc};
            rev_kmer = {rc, rev_kmer[KB-1:2]};
            read_pos++;
            if (win_fill < MAX_K) win_fill++;
            if (win_fill >= k) begin
                fkey = fwd_kmer & ({KB{1'b1}} >> (KB - 2 * k));
                rkey = rev_kmer >> (2 * (MAX_K - k));
                weigh_candidate(fkey, read_pos - k, 1'b0);
                if (!cur_no_rc) weigh_candidate(rkey, read_pos - 1, 1'b1);
            end
        end
        if (last) begin
            res = '0;
            if (have_best) begin
                res.found = 1'b1;
                res.key = best_key;
                res.offset = OFFSET_BITS'(best_rev ? (read_pos - 1) - best_pos : best_pos);
                res.rev = best_rev;
                res.weight = best_weight;
                if (bucket_count[best_key] != {COUNT_BITS{1'b1}})
                    bucket_count[best_key] = bucket_count[best_key] + 1'b1;
            end
            expected_results = {expected_results, res};
            fwd_kmer = '1;
            rev_kmer = '1;
            win_fill = 0;
            read_pos = 0;
            best_key = '0;
            best_weight = '0;
            best_pos = 0;
            best_rev = 1'b0;
            have_best = 1'b0;
        end
    endtask

    task automatic queue_base(input logic [CHAR_BITS-1:0] ch, input logic last);
        base_beat_t b;
        b.ch = ch;
        b.last = last;
        pending_bases = {pending_bases, b};
        queued_count++;
    endtask

    // A fresh random read, or a replay of an earlier one with perhaps one changed base.
    task automatic queue_read(input int force_len);
        int len;
        int src;
        int flip;
        int r;
        logic [CHAR_BITS-1:0] ch;
        r = $urandom_range(0, 99);
        if (force_len == 0 && lib_len.size() > 0 && r < 35) begin
            src = $urandom_range(0, lib_len.size() - 1);
            flip = ($urandom_range(0, 1) == 1) ? $urandom_range(0, lib_len[src] - 1) : -1;
            for (int i = 0; i < lib_len[src]; i++) begin
                ch = (i == flip) ? pick_char() : lib_chars[lib_start[src] + i];
                queue_base(ch, i == lib_len[src] - 1);
            end
        end else begin
            if (force_len > 0) len = force_len;
            else if (r < 85) len = $urandom_range(1, 16);
            else len = $urandom_range(17, 60);
            if (force_len == 0 && len <= 40 && lib_len.size() < 64) begin
                lib_start = {lib_start, lib_chars.size()};
                lib_len = {lib_len, len};
            end
            for (int i = 0; i < len; i++) begin
                ch = pick_char();
                if (force_len == 0 && len <= 40 && lib_len.size() <= 64 &&
                    lib_start[lib_start.size() - 1] + len > lib_chars.size())
                    lib_chars = {lib_chars, ch};
                queue_base(ch, i == len - 1);
            end
        end
    endtask

    task automatic queue_text(input string text);
        for (int i = 0; i < text.len(); i++)
            queue_base(text[i], i == text.len() - 1);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == kmhb_pkg::CFG_KMER_LENGTH) cur_klen = KLEN_BITS'(val);
        else cur_no_rc = val[0];
    endtask

    task automatic set_config(input int klen, input int no_rc);
        write_reg(kmhb_pkg::CFG_KMER_LENGTH, CFG_DATA_BITS'(klen));
        write_reg(kmhb_pkg::CFG_NO_RC, CFG_DATA_BITS'(no_rc));
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every queued base is taken and every predicted result has come back.
    task automatic wait_drained();
        do @(posedge aclk);
        while (accepted_count != queued_count || expected_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [COUNT_BITS-1:0] want,
                               input logic [COUNT_BITS-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Input driver: one base beat at a time from the pending queue, with random gaps.
    always @(posedge aclk) begin : drive_bases
        logic nxt_valid;
        base_beat_t b;
        if (aresetn) begin
            nxt_valid = s_valid;
            if (s_valid && s_ready) begin
                take_base(s_base_char, s_last_base);
                accepted_count++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_bases.size() > 0) begin
                    b = pending_bases.pop_front();
                    s_base_char <= b.ch;
                    s_last_base <= b.last;
                    nxt_valid = 1'b1;
                    send_gap = ($urandom_range(0, 99) < send_idle_pct) ? pick_gap() : 0;
                end
            end
            s_valid <= nxt_valid;
        end
    end

    // Receiver stalls, independent of whether a result beat is waiting.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 99) < recv_idle_pct) stall_left = pick_gap();
        end
    end

    // Result monitor: each accepted beat against the oldest prediction.
    always @(posedge aclk) begin : watch_results
        bucket_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual key %0h",
                         $time, m_bucket_key);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("found", COUNT_BITS'(want.found), COUNT_BITS'(m_found));
                check_field("bucket_key", COUNT_BITS'(want.key), COUNT_BITS'(m_bucket_key));
                check_field("first_offset", COUNT_BITS'(want.offset),
                            COUNT_BITS'(m_first_offset));
                check_field("reversed", COUNT_BITS'(want.rev), COUNT_BITS'(m_reversed));
                check_field("bucket_weight", want.weight, m_bucket_weight);
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Phase sequence: directed reads first, then random reads under several settings.
    initial begin : run_phases
        int klen_list[8];
        int no_rc_list[8];
        int start_count;
        klen_list = '{15, 1, 2, 3, 5, 10, 7, 4};
        no_rc_list = '{0, 1, 0, 1, 0, 1, 0, 0};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: a read too short for a k-mer, then one just past full length
        // with lowercase, N and a non-letter byte.
        send_idle_pct = 40;
        recv_idle_pct = 30;
        queue_text("ACG");
        queue_text(string'({"ACGTacgtN", 8'hFF, "T"}));
        wait_drained();
        repeat (8) @(posedge aclk);

        // Length 0 acts as 1: a two-base read, then a single-base read of a non-base byte.
        set_config(0, 0);
        queue_text("GC");
        queue_base(8'h00, 1'b1);
        wait_drained();
        repeat (8) @(posedge aclk);

        for (int p = 0; p < 8; p++) begin
            set_config(klen_list[p], no_rc_list[p]);
            send_idle_pct = (p % 3 == 2) ? 0 : 30;
            recv_idle_pct = (p % 4 == 3) ? 0 : 25;
            start_count = queued_count;
            while (queued_count - start_count < 120) queue_read(0);
            // A read of at least MAX_READ_LEN bases in a couple of phases: any tail past the limit is ignored.
            if (p == 1 || p == 5) queue_read($urandom_range(MAX_READ_LEN, MAX_READ_LEN + 40));
            wait_drained();
            repeat (8) @(posedge aclk);
        end

        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/kmhb_pkg.sv
rtl/kmhb_roller.sv
rtl/kmhb_count_mem.sv
rtl/kmhb_select.sv
rtl/kmer_heaviest_bucket_assign.sv
tb/tb_top.sv
